[sv/segment_segment_distance_sq_macros.svh]
// Assertion macros used by the port-level checker of the segment distance block.
`ifndef SEGMENT_SEGMENT_DISTANCE_SQ_MACROS_SVH
`define SEGMENT_SEGMENT_DISTANCE_SQ_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ssd_pkg.sv]
// Shared widths, constants and types of the segment distance pipeline.
package ssd_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W = 25;
   localparam int DOT_W = 50;
   localparam int PROD_W = 100;
   localparam int WIDE_W = 104;
   localparam int EPS_W = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd16;
   localparam int DIST_W = 52;
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [DOT_W-1:0] dot_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      coord_type [2:0] u;
      coord_type [2:0] v;
      diff_type [2:0] w0;
   } geom_type;

   typedef struct packed {
      dot_type a;
      dot_type b;
      dot_type c;
      dot_type d;
      dot_type e;
   } dots_type;

endpackage

[sv/ssd_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
module ssd_mul #(
   parameter int WA = 50,
   parameter int WB = 50
) (
   input  logic                    clock,
   input  logic [1:0]              en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int LA = (WA + 1) / 2;
   localparam int HA = WA - LA;
   localparam int LB = (WB + 1) / 2;
   localparam int HB = WB - LB;
   localparam int PW = WA + WB;
   localparam int W00 = LA + LB;
   localparam int W01 = LA + HB;
   localparam int W10 = HA + LB;
   localparam int W11 = HA + HB;

   logic [WA-1:0] ma;
   logic [WB-1:0] mb;
   logic [LA+LB-1:0] p00_ff, p00_in;
   logic [LA+HB-1:0] p01_ff, p01_in;
   logic [HA+LB-1:0] p10_ff, p10_in;
   logic [HA+HB-1:0] p11_ff, p11_in;
   logic neg_ff, neg_in;
   logic [PW-1:0] mag;
   logic signed [PW-1:0] p_ff, p_in;

   assign ma = $unsigned(a[WA-1] ? -a : a);
   assign mb = $unsigned(b[WB-1] ? -b : b);

   always_comb begin
      p00_in = W00'(ma[LA-1:0]) * W00'(mb[LB-1:0]);
      p01_in = W01'(ma[LA-1:0]) * W01'(mb[WB-1:LB]);
      p10_in = W10'(ma[WA-1:LA]) * W10'(mb[LB-1:0]);
      p11_in = W11'(ma[WA-1:LA]) * W11'(mb[WB-1:LB]);
      neg_in = a[WA-1] ^ b[WB-1];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         neg_ff <= neg_in;
      end
   end

   always_comb begin
      mag = PW'(p00_ff) + (PW'(p01_ff) << LB) + (PW'(p10_ff) << LA)
            + (PW'(p11_ff) << (LA + LB));
      p_in = neg_ff ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[sv/ssd_frac.sv]
// Pipelined restoring divider giving a clamped fraction num/den of 2^FRAC_BITS.
module ssd_frac #(
   parameter int FRAC_BITS = ssd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic [FRAC_BITS:0]   en,
   input  ssd_pkg::wide_type    num,
   input  ssd_pkg::wide_type    den,
   output logic [FRAC_BITS:0]   q
);

   localparam int W = ssd_pkg::WIDE_W;

   logic [W-1:0] r_ff [FRAC_BITS];
   logic [W-1:0] den_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff [FRAC_BITS+1];
   logic zero_ff [FRAC_BITS+1];
   logic one_ff [FRAC_BITS+1];
   logic zero_in, one_in;

   always_comb begin
      zero_in = (num <= 0);
      one_in = !zero_in && (num >= den);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0] <= $unsigned(num);
         den_ff[0] <= $unsigned(den);
         q_ff[0] <= '0;
         zero_ff[0] <= zero_in;
         one_ff[0] <= one_in;
      end
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
      logic [W-1:0] shl;
      logic ge;

      always_comb begin
         shl = r_ff[k-1] << 1;
         ge = (shl >= den_ff[k-1]);
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            q_ff[k] <= {q_ff[k-1][FRAC_BITS-2:0], ge};
            zero_ff[k] <= zero_ff[k-1];
            one_ff[k] <= one_ff[k-1];
         end
      end

      if (k < FRAC_BITS) begin : g_carry
         always_ff @(posedge clock) begin
            if (en[k]) begin
               r_ff[k] <= ge ? shl - den_ff[k-1] : shl;
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      if (one_ff[FRAC_BITS]) begin
         q = {1'b1, {FRAC_BITS{1'b0}}};
      end else if (zero_ff[FRAC_BITS]) begin
         q = '0;
      end else begin
         q = {1'b0, q_ff[FRAC_BITS]};
      end
   end

endmodule

[sv/segment_segment_distance_sq.sv]
// Throughput: one transaction per cycle unless the result is stalled with every
// stage full; each stage has its own valid bit and advances whenever the result
// is taken or it or any later stage is empty, so bubbles close up under stall.
// The depth is set by the fraction divider, one quotient bit per stage.
// Synchronous reset clears all valid bits and loads parallel epsilon with 16.
module segment_segment_distance_sq #(
   parameter int FRAC_BITS = ssd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ssd_pkg::EPS_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_origin_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_origin_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_origin_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_dir_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_dir_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_first_dir_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_origin_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_origin_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_origin_z,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_dir_x,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_dir_y,
   input  logic signed [ssd_pkg::COORD_W-1:0] req_second_dir_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssd_pkg::DIST_W-1:0]      rsp_dist_sq,
   output logic [FRAC_BITS:0]              rsp_s_param,
   output logic [FRAC_BITS:0]              rsp_t_param,
   output logic                            rsp_parallel_flag
);

   localparam int CW = ssd_pkg::COORD_W;
   localparam int DW = ssd_pkg::DIFF_W;
   localparam int OW = ssd_pkg::DOT_W;
   localparam int WW = ssd_pkg::WIDE_W;
   localparam int ST_W = FRAC_BITS + 1;
   localparam int WC_W = CW + ST_W + 1;
   localparam int SQ_W = 2 * WC_W;

   localparam int S_DOT = 1;
   localparam int S_MP = 2;
   localparam int S_MS = 3;
   localparam int S_DIF = 4;
   localparam int S_CL1 = 5;
   localparam int S_CL2 = 6;
   localparam int S_DV = 7;
   localparam int S_PM = S_DV + FRAC_BITS + 1;
   localparam int S_WC = S_PM + 1;
   localparam int S_QP = S_WC + 1;
   localparam int S_QS = S_QP + 1;
   localparam int S_OUT = S_QS + 1;
   localparam int NS = S_OUT + 1;

   logic [NS-1:0] v_ff, v_in, en;
   logic [ssd_pkg::EPS_W-1:0] eps_ff;

   ssd_pkg::coord_type p_pt [3], q_pt [3];
   ssd_pkg::geom_type geo_in;
   ssd_pkg::geom_type geo_ff [0:S_PM];
   ssd_pkg::dot_type uu_ff [3], uv_ff [3], vv_ff [3], uw_ff [3], vw_ff [3];
   ssd_pkg::dots_type dots_in;
   ssd_pkg::dots_type dots_ff [S_DOT:S_CL1];

   logic signed [ssd_pkg::PROD_W-1:0] ac, bb, be, cd, ae, bd;
   ssd_pkg::wide_type den_ff, sn_ff, tn_ff;
   ssd_pkg::wide_type sn1_ff, sd1_ff, tn1_ff, td1_ff;
   ssd_pkg::wide_type sn1_in, sd1_in, tn1_in, td1_in;
   ssd_pkg::wide_type snum_ff, sden_ff, tnum_ff, tden_ff;
   ssd_pkg::wide_type snum_in, sden_in, tnum_in, tden_in;
   ssd_pkg::wide_type eps_ext, c_w, e_w, b_w, d_w, a_w;
   logic par_in;
   logic par_ff [S_CL1:S_OUT];

   logic [ST_W-1:0] s_q, t_q;
   logic [ST_W-1:0] s_ff [S_PM:S_OUT];
   logic [ST_W-1:0] t_ff [S_PM:S_OUT];
   logic signed [WC_W-1:0] pu_ff [3], pv_ff [3], wc_ff [3];
   logic signed [SQ_W-1:0] sq [3];
   logic [SQ_W-1:0] sum;
   logic [ssd_pkg::DIST_W-1:0] dist_ff;

   // Handshake and stage valid bits.
   for (genvar g = 0; g < NS; g++) begin : g_en
      assign en[g] = rsp_ready || !(&v_ff[NS-1:g]);
   end

   always_comb begin
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         eps_ff <= ssd_pkg::EPS_RESET;
      end else begin
         v_ff <= v_in;
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];

   // Stage 0: direction products against directions and the origin offset.
   always_comb begin
      p_pt[0] = req_first_origin_x;
      p_pt[1] = req_first_origin_y;
      p_pt[2] = req_first_origin_z;
      q_pt[0] = req_second_origin_x;
      q_pt[1] = req_second_origin_y;
      q_pt[2] = req_second_origin_z;
      geo_in.u[0] = req_first_dir_x;
      geo_in.u[1] = req_first_dir_y;
      geo_in.u[2] = req_first_dir_z;
      geo_in.v[0] = req_second_dir_x;
      geo_in.v[1] = req_second_dir_y;
      geo_in.v[2] = req_second_dir_z;
      for (int i = 0; i < 3; i++) begin
         geo_in.w0[i] = DW'(p_pt[i]) - DW'(q_pt[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         geo_ff[0] <= geo_in;
         for (int i = 0; i < 3; i++) begin
            uu_ff[i] <= OW'($signed(geo_in.u[i])) * OW'($signed(geo_in.u[i]));
            uv_ff[i] <= OW'($signed(geo_in.u[i])) * OW'($signed(geo_in.v[i]));
            vv_ff[i] <= OW'($signed(geo_in.v[i])) * OW'($signed(geo_in.v[i]));
            uw_ff[i] <= OW'($signed(geo_in.u[i])) * OW'($signed(geo_in.w0[i]));
            vw_ff[i] <= OW'($signed(geo_in.v[i])) * OW'($signed(geo_in.w0[i]));
         end
      end
      for (int k = 1; k <= S_PM; k++) begin
         if (en[k]) begin
            geo_ff[k] <= geo_ff[k-1];
         end
      end
   end

   // Stage 1: dot products.
   always_comb begin
      dots_in.a = uu_ff[0] + uu_ff[1] + uu_ff[2];
      dots_in.b = uv_ff[0] + uv_ff[1] + uv_ff[2];
      dots_in.c = vv_ff[0] + vv_ff[1] + vv_ff[2];
      dots_in.d = uw_ff[0] + uw_ff[1] + uw_ff[2];
      dots_in.e = vw_ff[0] + vw_ff[1] + vw_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[S_DOT]) begin
         dots_ff[S_DOT] <= dots_in;
      end
      for (int k = S_DOT + 1; k <= S_CL1; k++) begin
         if (en[k]) begin
            dots_ff[k] <= dots_ff[k-1];
         end
      end
   end

   // Stages 2 and 3: products of dot products.
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_ac (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].a), .b(dots_ff[S_DOT].c), .p(ac));
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_bb (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].b), .b(dots_ff[S_DOT].b), .p(bb));
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_be (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].b), .b(dots_ff[S_DOT].e), .p(be));
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_cd (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].c), .b(dots_ff[S_DOT].d), .p(cd));
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_ae (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].a), .b(dots_ff[S_DOT].e), .p(ae));
   ssd_mul #(.WA(ssd_pkg::DOT_W), .WB(ssd_pkg::DOT_W)) u_mul_bd (
      .clock(clock), .en(en[S_MS:S_MP]),
      .a(dots_ff[S_DOT].b), .b(dots_ff[S_DOT].d), .p(bd));

   // Stage 4: determinant and unclamped numerators.
   always_ff @(posedge clock) begin
      if (en[S_DIF]) begin
         den_ff <= WW'(ac) - WW'(bb);
         sn_ff <= WW'(be) - WW'(cd);
         tn_ff <= WW'(ae) - WW'(bd);
      end
   end

   // Stage 5: parallel test and clamp of s.
   always_comb begin
      eps_ext = $signed({{(WW - ssd_pkg::EPS_W){1'b0}}, eps_ff});
      c_w = WW'($signed(dots_ff[S_DIF].c));
      e_w = WW'($signed(dots_ff[S_DIF].e));
      b_w = WW'($signed(dots_ff[S_DIF].b));
      par_in = $signed(den_ff >>> (2 * FRAC_BITS)) <= eps_ext;
      if (par_in) begin
         sn1_in = '0;
         sd1_in = c_w;
         tn1_in = e_w;
         td1_in = c_w;
      end else begin
         sn1_in = sn_ff;
         sd1_in = den_ff;
         tn1_in = tn_ff;
         td1_in = den_ff;
         if (sn_ff < 0) begin
            sn1_in = '0;
            tn1_in = e_w;
            td1_in = c_w;
         end else if (sn_ff > den_ff) begin
            sn1_in = den_ff;
            tn1_in = e_w + b_w;
            td1_in = c_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_CL1]) begin
         sn1_ff <= sn1_in;
         sd1_ff <= sd1_in;
         tn1_ff <= tn1_in;
         td1_ff <= td1_in;
         par_ff[S_CL1] <= par_in;
      end
      for (int k = S_CL1 + 1; k <= S_OUT; k++) begin
         if (en[k]) begin
            par_ff[k] <= par_ff[k-1];
         end
      end
   end

   // Stage 6: clamp of t, with s recomputed against the first segment.
   always_comb begin
      a_w = WW'($signed(dots_ff[S_CL1].a));
      d_w = WW'($signed(dots_ff[S_CL1].d));
      if (tn1_ff < 0) begin
         tnum_in = '0;
         tden_in = WW'(1);
         snum_in = -d_w;
         sden_in = a_w;
      end else if (tn1_ff > td1_ff) begin
         tnum_in = WW'(1);
         tden_in = WW'(1);
         snum_in = WW'($signed(dots_ff[S_CL1].b)) - d_w;
         sden_in = a_w;
      end else begin
         tnum_in = tn1_ff;
         tden_in = td1_ff;
         snum_in = sn1_ff;
         sden_in = sd1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_CL2]) begin
         snum_ff <= snum_in;
         sden_ff <= sden_in;
         tnum_ff <= tnum_in;
         tden_ff <= tden_in;
      end
   end

   // Stages 7 to 7 + FRAC_BITS: the two fraction dividers.
   ssd_frac #(.FRAC_BITS(FRAC_BITS)) u_frac_s (
      .clock(clock), .en(en[S_DV+FRAC_BITS:S_DV]),
      .num(snum_ff), .den(sden_ff), .q(s_q));
   ssd_frac #(.FRAC_BITS(FRAC_BITS)) u_frac_t (
      .clock(clock), .en(en[S_DV+FRAC_BITS:S_DV]),
      .num(tnum_ff), .den(tden_ff), .q(t_q));

   // Closest point offset and its squared length.
   always_ff @(posedge clock) begin
      if (en[S_PM]) begin
         s_ff[S_PM] <= s_q;
         t_ff[S_PM] <= t_q;
         for (int i = 0; i < 3; i++) begin
            pu_ff[i] <= WC_W'($signed(geo_ff[S_PM-1].u[i])) * WC_W'($signed({1'b0, s_q}));
            pv_ff[i] <= WC_W'($signed(geo_ff[S_PM-1].v[i])) * WC_W'($signed({1'b0, t_q}));
         end
      end
      for (int k = S_PM + 1; k <= S_OUT; k++) begin
         if (en[k]) begin
            s_ff[k] <= s_ff[k-1];
            t_ff[k] <= t_ff[k-1];
         end
      end
      if (en[S_WC]) begin
         for (int i = 0; i < 3; i++) begin
            wc_ff[i] <= (WC_W'($signed(geo_ff[S_PM].w0[i])) <<< FRAC_BITS)
                        + pu_ff[i] - pv_ff[i];
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sq
      ssd_mul #(.WA(WC_W), .WB(WC_W)) u_mul_sq (
         .clock(clock), .en(en[S_QS:S_QP]),
         .a(wc_ff[i]), .b(wc_ff[i]), .p(sq[i]));
   end

   assign sum = $unsigned(sq[0]) + $unsigned(sq[1]) + $unsigned(sq[2]);

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         dist_ff <= sum[2*FRAC_BITS +: ssd_pkg::DIST_W];
      end
   end

   assign rsp_dist_sq = dist_ff;
   assign rsp_s_param = s_ff[S_OUT];
   assign rsp_t_param = t_ff[S_OUT];
   assign rsp_parallel_flag = par_ff[S_OUT];

endmodule

[sv/ssd_checker.sv]
// Port-level checker for the segment distance block, bound to the top level.
`include "segment_segment_distance_sq_macros.svh"

module ssd_checker #(
   parameter int FRAC_BITS = ssd_pkg::FRAC_BITS_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ssd_pkg::DIST_W-1:0] rsp_dist_sq,
   input logic [FRAC_BITS:0]         rsp_s_param,
   input logic [FRAC_BITS:0]         rsp_t_param
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // Leaving reset, the pipeline is empty and takes a transaction at once.
   `SSD_ASSERT_SAME(a_reset_empty, $past(reset), req_ready && !rsp_valid, "pipeline not empty after reset")

   `SSD_ASSERT_SAME(a_s_range, rsp_valid, rsp_s_param <= ONE, "s parameter above one")

   `SSD_ASSERT_SAME(a_t_range, rsp_valid, rsp_t_param <= ONE, "t parameter above one")

   `SSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_dist_sq), "stalled result changed")

endmodule

bind segment_segment_distance_sq ssd_checker #(.FRAC_BITS(FRAC_BITS)) u_ssd_checker (.*);

[tb/sv/segment_segment_distance_sq_checker.sv]
// Checker that predicts and compares every result of the segment distance block.
module segment_segment_distance_sq_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [ssd_pkg::EPS_W-1:0]          csr_wr_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  ssd_pkg::coord_type [11:0]          req_fields,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [ssd_pkg::DIST_W-1:0]         rsp_dist_sq,
   input  logic [16:0]                        rsp_s_param,
   input  logic [16:0]                        rsp_t_param,
   input  logic                               rsp_parallel_flag,
   output int                                 failures,
   output int                                 pending
);
   import ssd_pkg::*;

   typedef logic signed [127:0] big_type;

   typedef struct {
      logic [DIST_W-1:0] dist_sq;
      logic [16:0]       s_param;
      logic [16:0]       t_param;
      logic              parallel_flag;
   } closest_type;

   localparam big_type ONE = 128'sd65536;
   localparam big_type DIST_TOP = (128'sd1 <<< DIST_W) - 1;

   closest_type closest_q[$];
   logic [EPS_W-1:0] epsilon;

   function automatic big_type clamp_ratio(big_type num, big_type den);
      if (num <= 0) return 0;
      if (num >= den) return ONE;
      return (num <<< 16) / den;
   endfunction

   function automatic closest_type closest_points(ssd_pkg::coord_type [11:0] f,
                                                  logic [EPS_W-1:0] eps);
      big_type u[3], v[3], w0[3], wc;
      big_type a, b, c, d, e, denom, sn, sd, tn, td, s, t, acc;
      logic par;
      closest_type r;
      a = 0; b = 0; c = 0; d = 0; e = 0;
      for (int i = 0; i < 3; i++) begin
         u[i] = f[3 + i];
         v[i] = f[9 + i];
         w0[i] = big_type'(f[i]) - big_type'(f[6 + i]);
         a += u[i] * u[i];
         b += u[i] * v[i];
         c += v[i] * v[i];
         d += u[i] * w0[i];
         e += v[i] * w0[i];
      end
      denom = a * c - b * b;
      par = (denom >>> 32) <= big_type'({1'b0, eps});
      if (par) begin
         sd = c; td = c; sn = 0; tn = e;
      end else begin
         sd = denom; td = denom;
         sn = b * e - c * d;
         tn = a * e - b * d;
         if (sn < 0) begin
            sn = 0; tn = e; td = c;
         end else if (sn > sd) begin
            sn = sd; tn = e + b; td = c;
         end
      end
      if (tn < 0) begin
         t = 0;
         s = clamp_ratio(-d, a);
      end else if (tn > td) begin
         t = ONE;
         s = clamp_ratio(b - d, a);
      end else begin
         t = clamp_ratio(tn, td);
         s = clamp_ratio(sn, sd);
      end
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         wc = w0[i] * ONE + u[i] * s - v[i] * t;
         acc += wc * wc;
      end
      acc = acc >>> 32;
      r.dist_sq = (acc > DIST_TOP) ? DIST_TOP[DIST_W-1:0] : acc[DIST_W-1:0];
      r.s_param = s[16:0];
      r.t_param = t[16:0];
      r.parallel_flag = par;
      return r;
   endfunction

   always @(posedge clock) begin
      closest_type want;
      if (reset) begin
         epsilon <= EPS_RESET;
         closest_q.delete();
      end else begin
         if (csr_wr_en) epsilon <= csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (closest_q.size() == 0) begin
               if (failures < 10) $display("unexpected result dist_sq=%h", rsp_dist_sq);
               failures++;
            end else begin
               want = closest_q.pop_front();
               if (want.dist_sq !== rsp_dist_sq || want.s_param !== rsp_s_param ||
                   want.t_param !== rsp_t_param ||
                   want.parallel_flag !== rsp_parallel_flag) begin
                  if (failures < 10)
                     $display("mismatch: expected d=%h s=%h t=%h p=%b, got d=%h s=%h t=%h p=%b",
                              want.dist_sq, want.s_param, want.t_param, want.parallel_flag,
                              rsp_dist_sq, rsp_s_param, rsp_t_param, rsp_parallel_flag);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) closest_q.push_back(closest_points(req_fields, epsilon));
      end
      pending = closest_q.size();
   end

   initial begin
      failures = 0;
      pending = 0;
   end
endmodule

[tb/sv/testbench.sv]
// Top of the segment distance testbench: stimulus, flow control and verdict.
module testbench;
   import ssd_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [EPS_W-1:0] csr_wr_data = 0;
   logic req_valid = 0;
   logic req_ready;
   coord_type [11:0] req_fields = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [DIST_W-1:0] rsp_dist_sq;
   logic [16:0] rsp_s_param, rsp_t_param;
   logic rsp_parallel_flag;
   int failures, pending;
   int idle_pct = 0, stall_pct = 0, hold_cycles = 0;

   always #4 clock = ~clock;

   segment_segment_distance_sq uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_origin_x(req_fields[0]), .req_first_origin_y(req_fields[1]),
      .req_first_origin_z(req_fields[2]), .req_first_dir_x(req_fields[3]),
      .req_first_dir_y(req_fields[4]), .req_first_dir_z(req_fields[5]),
      .req_second_origin_x(req_fields[6]), .req_second_origin_y(req_fields[7]),
      .req_second_origin_z(req_fields[8]), .req_second_dir_x(req_fields[9]),
      .req_second_dir_y(req_fields[10]), .req_second_dir_z(req_fields[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_dist_sq(rsp_dist_sq),
      .rsp_s_param(rsp_s_param), .rsp_t_param(rsp_t_param),
      .rsp_parallel_flag(rsp_parallel_flag)
   );

   segment_segment_distance_sq_checker checker_inst (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_fields(req_fields),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_dist_sq(rsp_dist_sq),
      .rsp_s_param(rsp_s_param), .rsp_t_param(rsp_t_param),
      .rsp_parallel_flag(rsp_parallel_flag), .failures(failures), .pending(pending)
   );

   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_segments(coord_type [11:0] f);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_fields <= f;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_epsilon(logic [EPS_W-1:0] value);
      req_valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic coord_type ranged(int span);
      return coord_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic coord_type [11:0] random_segments();
      coord_type [11:0] f;
      int mode, k;
      mode = $urandom_range(99);
      for (int i = 0; i < 12; i++) f[i] = ranged(1 << 17);
      if (mode < 15) begin
         for (int i = 0; i < 12; i++) f[i] = coord_type'($urandom());
      end else if (mode < 27) begin
         k = $urandom_range(4) - 2;
         for (int i = 0; i < 3; i++) f[9 + i] = coord_type'(f[3 + i] * k);
      end else if (mode < 35) begin
         for (int i = 3; i < 6; i++) f[i] = '0;
         if ($urandom_range(1)) for (int i = 9; i < 12; i++) f[i] = '0;
      end else if (mode < 42) begin
         for (int i = 0; i < 12; i++) f[i] = ranged(4);
      end
      return f;
   endfunction

   task automatic directed_segments();
      coord_type [11:0] f;
      f = '0; send_segments(f);
      f = {12{24'sh7FFFFF}}; send_segments(f);
      f = {12{24'sh800000}}; send_segments(f);
      f = {6{24'sh7FFFFF, 24'sh800000}}; send_segments(f);
      f = {6{24'sh800000, 24'sh7FFFFF}}; send_segments(f);
      f = '0; f[0] = 24'sh7FFFFF; f[6] = 24'sh800000; f[1] = 24'sh7FFFFF;
      f[7] = 24'sh800000; send_segments(f);
      f = '0; f[3] = 24'sd65536; f[9] = 24'sd65536; f[7] = 24'sd65536; send_segments(f);
      f = '0; f[9] = 24'sd65536; f[0] = 24'sd32768; f[6] = -24'sd100000; send_segments(f);
      f = '0; f[0] = 24'sd1000; f[6] = 24'sd9; send_segments(f);
      f = '0; f[3] = 24'sd131072; f[6] = 24'sd65536; f[7] = -24'sd65536;
      f[10] = 24'sd131072; f[8] = 24'sd40000; send_segments(f);
      f = '0; f[3] = 24'sd65536; f[6] = 24'sd300000; f[9] = -24'sd65536; send_segments(f);
      f = '0; f[3] = 24'sd65536; f[6] = -24'sd300000; f[10] = 24'sd65536;
      f[7] = 24'sd200000; send_segments(f);
      f = '0; f[3] = 24'sd1; f[10] = 24'sd1; f[6] = 24'sd5; send_segments(f);
      f = '0; f[4] = 24'sd300; f[11] = 24'sd300; f[8] = 24'sd77; send_segments(f);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      directed_segments();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 54; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 54; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         case (phase)
            0: write_epsilon(16'd0);
            1: write_epsilon(16'hFFFF);
            3: write_epsilon(16'd16);
            5: write_epsilon(16'hFFFF);
            7: write_epsilon(16'd0);
            default: write_epsilon(16'($urandom()));
         endcase
         if (phase == 4) hold_cycles = 300;
         repeat (150) send_segments(random_segments());
      end
      req_valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
